FILE: rtl/kve_pkg.sv
// ----------------------------------------------------------------------------
// Keyword value extractor package
// Shared constants, types and the saturating decimal digit step.
// ----------------------------------------------------------------------------
package kve_pkg;

   // Keyword geometry.
   localparam int MAX_KEY_LEN = 8;
   localparam int CHAR_W      = 8;
   localparam int KEY_BYTES_W = CHAR_W * MAX_KEY_LEN;
   localparam int KEY_LEN_W   = 4;

   // Parsed value geometry.
   localparam int VALUE_W                 = 31;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   // Character codes of the decimal digits.
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 1'b1;

   // One message character as held in the input register.
   typedef struct packed {
      logic [CHAR_W-1:0] rx_byte;
      logic              end_of_message;
   } item_type;

   // Handshake between the input register and the parse core.
   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   // Result of one saturating digit step.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               overflow;
   } acc_result_type;

   // Multiply the accumulator by ten and add a digit, saturating at the maximum.
   function automatic acc_result_type add_digit(input logic [VALUE_W-1:0] acc,
                                                input logic [3:0]         digit);
      logic [VALUE_W+3:0] sum;
      acc_result_type     res;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_W{1'b0}}, digit};
      res.overflow = |sum[VALUE_W+3:VALUE_W];
      res.value    = res.overflow ? VALUE_MAX : sum[VALUE_W-1:0];
      return res;
   endfunction

endpackage

FILE: rtl/kve_in_reg.sv
// ----------------------------------------------------------------------------
// Keyword value extractor input register
// Captures one request transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module kve_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_end_of_message,
   input  logic                   advance,
   output kve_pkg::stage_type     stage
);
   import kve_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   // The register can take a new character when empty or when it empties now.
   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.rx_byte        <= req_rx_byte;
         item_ff.end_of_message <= req_end_of_message;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: rtl/kve_parse_core.sv
// ----------------------------------------------------------------------------
// Keyword value extractor parse core
// Keyword window compare, digit accumulation and the result register.
// ----------------------------------------------------------------------------
module kve_parse_core (
   input  logic                               clock,
   input  logic                               reset,
   input  kve_pkg::stage_type                 stage,
   output logic                               advance,
   input  logic                               csr_wr_en,
   input  logic [kve_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kve_pkg::KEY_BYTES_W-1:0]    csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kve_pkg::VALUE_W-1:0]        rsp_parsed_value,
   output logic                               rsp_keyword_found,
   output logic                               rsp_value_overflow
);
   import kve_pkg::*;

   // Configuration registers.
   logic [KEY_BYTES_W-1:0] key_bytes_ff;
   logic [KEY_LEN_W-1:0]   key_length_ff;

   // Message state.
   logic [CHAR_W-1:0]    window_ff [MAX_KEY_LEN];
   logic [CHAR_W-1:0]    window_in [MAX_KEY_LEN];
   logic [KEY_LEN_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic                 match_seen_ff, match_seen_in;
   logic [VALUE_W-1:0]   prefix_value_ff, prefix_value_in;
   logic                 prefix_open_ff, prefix_open_in;
   logic [VALUE_W-1:0]   after_value_ff, after_value_in;
   logic                 after_open_ff, after_open_in;
   logic [1:0]           overflow_ff, overflow_in;

   // Result register.
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_found_ff;
   logic               rsp_overflow_ff;

   logic [CHAR_W-1:0]      chr;
   logic [CHAR_W-1:0]      digit_full;
   logic                   is_digit;
   logic                   last;
   logic                   finish;
   logic [MAX_KEY_LEN-1:0] match_len;
   logic                   hit;
   acc_result_type         prefix_add;
   acc_result_type         after_add;

   assign chr        = stage.item.rx_byte;
   assign last       = stage.item.end_of_message;
   assign is_digit   = (chr >= CHAR_ZERO) && (chr <= CHAR_NINE);
   assign digit_full = chr - CHAR_ZERO;
   assign prefix_add = add_digit(prefix_value_ff, digit_full[3:0]);
   assign after_add  = add_digit(after_value_ff, digit_full[3:0]);

   // A character moves on unless it ends a message while the result is still held.
   assign advance = stage.valid && (!last || !rsp_valid_ff || rsp_ready);
   assign finish  = advance && last;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_BYTES:  key_bytes_ff  <= csr_wdata;
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[KEY_LEN_W-1:0];
            default:        key_bytes_ff  <= key_bytes_ff;
         endcase
      end
   end

   // Window after shifting in the current character, newest in slot zero.
   always_comb begin
      window_in[0] = chr;
      for (int i = 1; i < MAX_KEY_LEN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Compare the shifted window for every possible keyword length in parallel.
   always_comb begin
      for (int l = 1; l <= MAX_KEY_LEN; l++) begin
         match_len[l-1] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (window_in[l-1-i] != key_bytes_ff[CHAR_W*i +: CHAR_W]) begin
               match_len[l-1] = 1'b0;
            end
         end
      end
   end

   // Select the configured length; a zero or oversized length never matches.
   always_comb begin
      hit = 1'b0;
      for (int l = 1; l <= MAX_KEY_LEN; l++) begin
         if (key_length_ff == KEY_LEN_W'(l) && bytes_seen_in >= KEY_LEN_W'(l)) begin
            hit = match_len[l-1];
         end
      end
   end

   // Saturating count of characters seen before the first match.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (!match_seen_ff && bytes_seen_ff < KEY_LEN_W'(MAX_KEY_LEN)) begin
         bytes_seen_in = bytes_seen_ff + 1'b1;
      end
   end

   // Next message state for the current character.
   always_comb begin
      prefix_value_in = prefix_value_ff;
      prefix_open_in  = prefix_open_ff;
      after_value_in  = after_value_ff;
      after_open_in   = after_open_ff;
      match_seen_in   = match_seen_ff;
      overflow_in     = overflow_ff;

      // Digit run at the start of the message.
      if (prefix_open_ff) begin
         if (is_digit) begin
            prefix_value_in = prefix_add.value;
            if (prefix_add.overflow) begin
               overflow_in[0] = 1'b1;
            end
         end else begin
            prefix_open_in = 1'b0;
         end
      end

      // Digit run after the keyword, or the search for it.
      if (match_seen_ff) begin
         if (after_open_ff) begin
            if (is_digit) begin
               after_value_in = after_add.value;
               if (after_add.overflow) begin
                  overflow_in[1] = 1'b1;
               end
            end else begin
               after_open_in = 1'b0;
            end
         end
      end else if (hit) begin
         match_seen_in  = 1'b1;
         after_open_in  = 1'b1;
         after_value_in = '0;
      end
   end

   // Message state registers; the end of a message returns them to reset.
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         for (int i = 0; i < MAX_KEY_LEN; i++) begin
            window_ff[i] <= '0;
         end
         bytes_seen_ff   <= '0;
         match_seen_ff   <= 1'b0;
         prefix_value_ff <= '0;
         prefix_open_ff  <= 1'b1;
         after_value_ff  <= '0;
         after_open_ff   <= 1'b0;
         overflow_ff     <= '0;
      end else if (advance) begin
         if (!match_seen_ff) begin
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
               window_ff[i] <= window_in[i];
            end
         end
         bytes_seen_ff   <= bytes_seen_in;
         match_seen_ff   <= match_seen_in;
         prefix_value_ff <= prefix_value_in;
         prefix_open_ff  <= prefix_open_in;
         after_value_ff  <= after_value_in;
         after_open_ff   <= after_open_in;
         overflow_ff     <= overflow_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: the keyword run if the keyword was seen, else the prefix run.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_found_ff    <= match_seen_in;
         rsp_value_ff    <= match_seen_in ? after_value_in : prefix_value_in;
         rsp_overflow_ff <= match_seen_in ? overflow_in[1] : overflow_in[0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_parsed_value   = rsp_value_ff;
   assign rsp_keyword_found  = rsp_found_ff;
   assign rsp_value_overflow = rsp_overflow_ff;

endmodule

FILE: rtl/keyword_value_extractor.sv
// Path: the last character passes through the input register, then the result register.
// Throughput: one character per cycle; the input register and the result register
// decouple the two channels, and only a held result stalls a message's last character.
// Reset: synchronous, active high; clears the keyword configuration, all message
// state and both valid flags.
// ----------------------------------------------------------------------------
// Keyword value extractor
// Finds a configured keyword in a character stream and parses the decimal
// value that follows it, or else the leading digit run, reporting once per message.
// ----------------------------------------------------------------------------
module keyword_value_extractor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   input  logic                               req_end_of_message,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kve_pkg::VALUE_W-1:0]        rsp_parsed_value,
   output logic                               rsp_keyword_found,
   output logic                               rsp_value_overflow,
   input  logic                               csr_wr_en,
   input  logic [kve_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kve_pkg::KEY_BYTES_W-1:0]    csr_wdata
);
   import kve_pkg::*;

   stage_type stage;
   logic      advance;

   // Input register.
   kve_in_reg u_in_reg (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_message (req_end_of_message),
      .advance            (advance),
      .stage              (stage)
   );

   // Search, accumulation and result register.
   kve_parse_core u_core (
      .clock              (clock),
      .reset              (reset),
      .stage              (stage),
      .advance            (advance),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parsed_value   (rsp_parsed_value),
      .rsp_keyword_found  (rsp_keyword_found),
      .rsp_value_overflow (rsp_value_overflow)
   );

endmodule

FILE: rtl/kve_checker.sv
// ----------------------------------------------------------------------------
// Keyword value extractor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module kve_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [kve_pkg::VALUE_W-1:0]        rsp_parsed_value,
   input logic                               rsp_keyword_found,
   input logic                               rsp_value_overflow
);
   import kve_pkg::*;

   // A held result stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // A held result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_parsed_value) && $stable(rsp_keyword_found)
                                  && $stable(rsp_value_overflow))
      else $error("result payload changed while held");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The request side only stalls behind a result that is not being taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held result");

   // An overflowed value is reported saturated.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_overflow |-> rsp_parsed_value == VALUE_MAX)
      else $error("overflow reported without saturation");

endmodule

bind keyword_value_extractor kve_checker u_kve_checker (.*);
